/* sv/vcc_pkg.sv */
// ---------------------------------------------------------------------------
// vcc_pkg: shared types and constants of the vertical column convolution
// Field widths, register indexes, reset values and the control bundle that
// the top level hands to every tap cell.
// ---------------------------------------------------------------------------
package vcc_pkg;

    localparam int ROW_WIDTH_BITS = 11;
    localparam int TAP_COUNT_BITS = 3;
    localparam int WEIGHT_BITS    = 16;
    localparam int FILT_BITS      = 35;
    localparam int ROWS_BITS      = 3;
    localparam int NUM_WEIGHTS    = 5;
    localparam int WEIGHT_IDX_BITS = 3;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TAP_COUNT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_UP2 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_UP1 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_MID = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_DN1 = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_DN2 = 3'd6;

    // slots of the weight bank, ordered by row offset -2..+2
    localparam logic [WEIGHT_IDX_BITS-1:0] W_UP2 = 3'd0;
    localparam logic [WEIGHT_IDX_BITS-1:0] W_UP1 = 3'd1;
    localparam logic [WEIGHT_IDX_BITS-1:0] W_MID = 3'd2;
    localparam logic [WEIGHT_IDX_BITS-1:0] W_DN1 = 3'd3;
    localparam logic [WEIGHT_IDX_BITS-1:0] W_DN2 = 3'd4;

    localparam logic [ROW_WIDTH_BITS-1:0]  ROW_WIDTH_RST = 11'd1024;
    localparam logic [TAP_COUNT_BITS-1:0]  TAP_COUNT_RST = 3'd5;
    localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_RST = 16'sd1;
    localparam logic [ROWS_BITS-1:0]       ROWS_MAX      = 3'd7;

    typedef struct packed {
        logic rd_en;    // new request: read the line buffers
        logic wr_en;    // request leaving the read stage: shift history down
        logic fwd_hit;  // new request hits the column being written this edge
        logic adv;      // pipeline advances
    } t_cell_ctl;

endpackage

/* sv/vcc_ram.sv */
// ---------------------------------------------------------------------------
// vcc_ram: generic simple dual-port RAM
// One write port, one read port with a registered, enabled read.
// ---------------------------------------------------------------------------
module vcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/vcc_cell.sv */
// ---------------------------------------------------------------------------
// vcc_cell: one tap of the column filter
// Holds one row of history in a line buffer unless it is the head cell,
// takes the sample handed down from above, multiplies its own by its weight.
// ---------------------------------------------------------------------------
module vcc_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_WIDTH   = 1024,
    parameter bit HAS_LINE    = 1'b1
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  vcc_pkg::t_cell_ctl                     i_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0]           i_rd_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0]           i_wr_addr,
    input  logic signed [SAMPLE_BITS-1:0]          i_prev_val,
    input  logic signed [vcc_pkg::WEIGHT_BITS-1:0] i_weight,
    output logic signed [SAMPLE_BITS-1:0]          o_val,
    output logic signed [SAMPLE_BITS+vcc_pkg::WEIGHT_BITS-1:0] o_prod
);
    import vcc_pkg::*;

    localparam int PW = SAMPLE_BITS + WEIGHT_BITS;

    logic signed [PW-1:0] r_prod;

    generate
        if (HAS_LINE) begin : g_line
            logic [SAMPLE_BITS-1:0]        rd_data;
            logic                          r_fwd_hit;
            logic signed [SAMPLE_BITS-1:0] r_fwd_val;

            vcc_ram #(
                .WIDTH (SAMPLE_BITS),
                .DEPTH (MAX_WIDTH)
            ) u_ram (
                .i_clk   (i_clk),
                .i_we    (i_ctl.wr_en),
                .i_waddr (i_wr_addr),
                .i_wdata (i_prev_val),
                .i_re    (i_ctl.rd_en),
                .i_raddr (i_rd_addr),
                .o_rdata (rd_data)
            );

            // catch the write that lands on the same column as this read
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_fwd_hit <= 1'b0;
                end else if (i_ctl.rd_en) begin
                    r_fwd_hit <= i_ctl.fwd_hit;
                end
                if (i_ctl.rd_en) begin
                    r_fwd_val <= i_prev_val;
                end
            end

            assign o_val = r_fwd_hit ? r_fwd_val : $signed(rd_data);
        end else begin : g_head
            assign o_val = i_prev_val;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_prod <= o_val * i_weight;
        end
    end

    assign o_prod = r_prod;

endmodule

/* sv/vertical_column_convolution.sv */
// ---------------------------------------------------------------------------
// vertical_column_convolution: vertical FIR over a row-major sample stream
// Line-buffered column filter of up to five taps built as a chain of cells.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): one sample per request, row-major,
//   i_frame_start on the first sample of a grid clears the column and row
//   counters. Output channel (o_valid / i_stall): one result per request
//   once 2p rows of the grid have passed, p = (tap_count - 1) / 2; earlier
//   samples only fill the line buffers and give no result.
//   Throughput: one request per cycle unless a refused result stalls the
//   pipeline. Each tap cell but the head owns one line buffer with one read
//   and one write port, so the read of a column and the write-back of the
//   previous sample happen in the same cycle. A request passes the buffer
//   read, multiply, pair add and final add on its way to o_valid.
//   Stall: while a result waits with i_stall high the whole pipeline holds
//   and o_stall is raised; a waiting result that is taken frees the input in
//   the same cycle.
//   Reset: i_rst_n (synchronous, active low) empties the pipeline, clears
//   the counters and loads the default registers. The line buffers are not
//   cleared; results use them only after 2p fresh rows have been written.
//   Configuration is written through i_cfg_wr_en / i_cfg_idx / i_cfg_data
//   while the block is idle.
// ---------------------------------------------------------------------------
module vertical_column_convolution #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_TAPS    = 5,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic signed [SAMPLE_BITS-1:0]            i_sample,
    input  logic                                     i_frame_start,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic signed [vcc_pkg::FILT_BITS-1:0]     o_filtered,
    output logic                                     o_row_end,
    input  logic                                     i_cfg_wr_en,
    input  logic [vcc_pkg::CFG_IDX_BITS-1:0]         i_cfg_idx,
    input  logic [vcc_pkg::CFG_DATA_BITS-1:0]        i_cfg_data
);
    import vcc_pkg::*;

    localparam int PMAX_RAW = (MAX_TAPS - 1) / 2;
    localparam int PMAX     = (PMAX_RAW > 2) ? 2 : PMAX_RAW;
    localparam int NCELL    = 2 * PMAX + 1;
    localparam int NPAIR    = (NCELL + 1) / 2;
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int MWB      = $clog2(MAX_WIDTH + 1);
    localparam int LW       = ((MWB > ROW_WIDTH_BITS) ? MWB : ROW_WIDTH_BITS) + 1;
    localparam int PW       = SAMPLE_BITS + WEIGHT_BITS;
    localparam int AW       = PW + 3;

    // configuration registers
    logic [ROW_WIDTH_BITS-1:0]     r_row_width;
    logic [TAP_COUNT_BITS-1:0]     r_tap_count;
    logic signed [WEIGHT_BITS-1:0] r_weight [NUM_WEIGHTS];

    // stream position
    logic [CW-1:0]        r_col_pos;
    logic [ROWS_BITS-1:0] r_rows;

    // read stage
    logic                          r_a_valid;
    logic                          r_a_emit;
    logic                          r_a_last;
    logic signed [SAMPLE_BITS-1:0] r_a_cur;
    logic [CW-1:0]                 r_a_col;

    // product stage (products live in the cells)
    logic r_b_valid;
    logic r_b_last;

    // pair-sum stage
    logic signed [AW-1:0] r_c_pair [NPAIR];
    logic signed [AW-1:0] n_c_pair [NPAIR];
    logic                 r_c_valid;
    logic                 r_c_last;

    // output register
    logic signed [FILT_BITS-1:0] r_out;
    logic signed [AW-1:0]        n_out;
    logic                        r_out_valid;
    logic                        r_out_last;

    logic                 en;
    logic                 accept;
    logic [1:0]           p_raw;
    logic [1:0]           p;
    logic [LW-1:0]        width_eff;
    logic [CW-1:0]        col_eff;
    logic [ROWS_BITS-1:0] rows_eff;
    logic                 last;
    logic                 emit;
    t_cell_ctl            cell_ctl;

    logic signed [SAMPLE_BITS-1:0] cell_val  [NCELL];
    logic signed [PW-1:0]          cell_prod [NCELL];
    logic signed [WEIGHT_BITS-1:0] cell_w    [NCELL];

    // ---- configuration port -------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RST;
            r_tap_count <= TAP_COUNT_RST;
            for (int k = 0; k < NUM_WEIGHTS; k++) begin
                r_weight[k] <= WEIGHT_RST;
            end
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_ROW_WIDTH:  r_row_width <= i_cfg_data[ROW_WIDTH_BITS-1:0];
                REG_TAP_COUNT:  r_tap_count <= i_cfg_data[TAP_COUNT_BITS-1:0];
                REG_WEIGHT_UP2: r_weight[W_UP2] <= i_cfg_data;
                REG_WEIGHT_UP1: r_weight[W_UP1] <= i_cfg_data;
                REG_WEIGHT_MID: r_weight[W_MID] <= i_cfg_data;
                REG_WEIGHT_DN1: r_weight[W_DN1] <= i_cfg_data;
                REG_WEIGHT_DN2: r_weight[W_DN2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- handshake -----------------------------------------------------
    // Hold everything while a finished result is refused downstream.
    assign en      = !(r_out_valid && i_stall);
    assign accept  = i_valid && en;
    assign o_stall = !en;

    // ---- row bookkeeping ----------------------------------------------
    // Half the kernel height, clamped to what the chain of cells can hold.
    always_comb begin
        p_raw = (r_tap_count == '0) ? 2'd0 : 2'((r_tap_count - 3'd1) >> 1);
        p     = (p_raw > 2'(PMAX)) ? 2'(PMAX) : p_raw;
    end

    // Treat width 0 as 1 and clamp oversize widths to the buffer depth.
    always_comb begin
        if (r_row_width == '0) begin
            width_eff = LW'(1);
        end else if (LW'(r_row_width) > LW'(MAX_WIDTH)) begin
            width_eff = LW'(MAX_WIDTH);
        end else begin
            width_eff = LW'(r_row_width);
        end
    end

    // A frame start clears the counters before the sample is used.
    assign col_eff  = i_frame_start ? '0 : r_col_pos;
    assign rows_eff = i_frame_start ? '0 : r_rows;
    assign last     = (LW'(col_eff) + LW'(1)) >= width_eff;
    assign emit     = rows_eff >= {p, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos <= '0;
            r_rows    <= '0;
        end else if (accept) begin
            if (last) begin
                r_col_pos <= '0;
                r_rows    <= (rows_eff == ROWS_MAX) ? ROWS_MAX : rows_eff + 3'd1;
            end else begin
                r_col_pos <= col_eff + CW'(1);
                r_rows    <= rows_eff;
            end
        end
    end

    // ---- read stage ----------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
        end
        if (accept) begin
            r_a_emit <= emit;
            r_a_last <= last;
            r_a_cur  <= i_sample;
            r_a_col  <= col_eff;
        end
    end

    // Shift history down on the way out of the read stage; forward when the
    // next request reads the very column being written.
    always_comb begin
        cell_ctl.rd_en   = accept;
        cell_ctl.wr_en   = en && r_a_valid;
        cell_ctl.fwd_hit = r_a_valid && (r_a_col == col_eff);
        cell_ctl.adv     = en;
    end

    // Cell b looks b rows back; it takes the weight of row offset p - b,
    // and nothing once it lies beyond the window.
    always_comb begin
        for (int b = 0; b < NCELL; b++) begin
            if (b <= 2 * int'(p)) begin
                cell_w[b] = r_weight[WEIGHT_IDX_BITS'(int'(p) + 2 - b)];
            end else begin
                cell_w[b] = '0;
            end
        end
    end

    // ---- chain of tap cells -------------------------------------------
    generate
        for (genvar b = 0; b < NCELL; b++) begin : g_cell
            logic signed [SAMPLE_BITS-1:0] prev_val;

            if (b == 0) begin : g_first
                assign prev_val = r_a_cur;
            end else begin : g_next
                assign prev_val = cell_val[b-1];
            end

            vcc_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .MAX_WIDTH   (MAX_WIDTH),
                .HAS_LINE    (b > 0)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (cell_ctl),
                .i_rd_addr  (col_eff),
                .i_wr_addr  (r_a_col),
                .i_prev_val (prev_val),
                .i_weight   (cell_w[b]),
                .o_val      (cell_val[b]),
                .o_prod     (cell_prod[b])
            );
        end
    endgenerate

    // ---- product stage control ----------------------------------------
    // Drop requests that only fill the buffers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid && r_a_emit;
        end
        if (en) begin
            r_b_last <= r_a_last;
        end
    end

    // ---- pair sums -----------------------------------------------------
    always_comb begin
        for (int j = 0; j < NPAIR; j++) begin
            if (2 * j + 1 < NCELL) begin
                n_c_pair[j] = AW'(cell_prod[2*j]) + AW'(cell_prod[2*j+1]);
            end else begin
                n_c_pair[j] = AW'(cell_prod[2*j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= r_b_valid;
        end
        if (en) begin
            r_c_last <= r_b_last;
            for (int j = 0; j < NPAIR; j++) begin
                r_c_pair[j] <= n_c_pair[j];
            end
        end
    end

    // ---- final sum and output register --------------------------------
    always_comb begin
        n_out = '0;
        for (int j = 0; j < NPAIR; j++) begin
            n_out = n_out + r_c_pair[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_c_valid;
        end
        if (en) begin
            r_out      <= FILT_BITS'(n_out);
            r_out_last <= r_c_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_filtered = r_out;
    assign o_row_end  = r_out_last;

endmodule

/* sv/vcc_checker.sv */
// ---------------------------------------------------------------------------
// vcc_checker: port-level checks of the vertical column convolution
// Watches the two channels of the top level; bound in below.
// ---------------------------------------------------------------------------
module vcc_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_stall,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic signed [vcc_pkg::FILT_BITS-1:0] o_filtered,
    input logic                                 o_row_end
);

    // reset empties the pipeline and frees the input
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    // input is only held back by a refused result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a refused result");

    // a refused result stays in place
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_filtered) && $stable(o_row_end))
        else $error("refused result changed");

endmodule

bind vertical_column_convolution vcc_checker u_vcc_checker (.*);
